// ===== design/lcm_pkg.sv =====
package lcm_pkg;

  localparam int OPERAND_WIDTH = 31;
  localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
  localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

  typedef struct packed {
    logic [OPERAND_WIDTH-1:0] operand_a;
    logic [OPERAND_WIDTH-1:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic [PROD_WIDTH-1:0]    lcm_value;
    logic [OPERAND_WIDTH-1:0] gcd_value;
    logic                     zero_operand_error;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MOD_RUN,
    ST_MOD_EVAL,
    ST_LCM_RUN,
    ST_MUL,
    ST_OUT
  } lcm_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel_lcm;
    logic div_step;
    logic swap;
    logic set_zero;
    logic mul;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_op;
    logic last_step;
    logic rem_zero;
  } dp_status_t;

endpackage

// ===== design/lcm_datapath.sv =====
module lcm_datapath (
  input  logic               clk,
  input  lcm_pkg::in_word_t  in_data,
  input  lcm_pkg::dp_cmd_t   cmd,
  output lcm_pkg::dp_status_t status,
  output lcm_pkg::out_word_t out_data
);

  logic [lcm_pkg::OPERAND_WIDTH-1:0] a_r;
  logic [lcm_pkg::OPERAND_WIDTH-1:0] b_r;
  logic [lcm_pkg::OPERAND_WIDTH-1:0] big;
  logic [lcm_pkg::OPERAND_WIDTH-1:0] small_op;
  logic [lcm_pkg::OPERAND_WIDTH-1:0] dvd;
  logic [lcm_pkg::OPERAND_WIDTH-1:0] dsr;
  logic [lcm_pkg::OPERAND_WIDTH-1:0] part;
  logic [lcm_pkg::CNT_WIDTH-1:0]     cnt;
  lcm_pkg::out_word_t                result;

  logic [lcm_pkg::OPERAND_WIDTH:0]   shifted;
  logic [lcm_pkg::OPERAND_WIDTH+1:0] diff;
  logic                              ge;
  logic [lcm_pkg::PROD_WIDTH-1:0]    prod;

  // one restoring divide step: bring down the next dividend bit
  assign shifted = {part, dvd[lcm_pkg::OPERAND_WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr};
  assign ge      = ~diff[lcm_pkg::OPERAND_WIDTH+1];
  assign prod    = lcm_pkg::PROD_WIDTH'(dvd) * lcm_pkg::PROD_WIDTH'(b_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= in_data.operand_a;
      b_r <= in_data.operand_b;
      if (in_data.operand_a < in_data.operand_b) begin
        big      <= in_data.operand_b;
        small_op <= in_data.operand_a;
      end else begin
        big      <= in_data.operand_a;
        small_op <= in_data.operand_b;
      end
    end else if (cmd.swap) begin
      big      <= small_op;
      small_op <= part;
    end

    if (cmd.div_start) begin
      dvd  <= cmd.div_sel_lcm ? a_r : big;
      dsr  <= small_op;
      part <= '0;
      cnt  <= lcm_pkg::CNT_WIDTH'(lcm_pkg::OPERAND_WIDTH - 1);
    end else if (cmd.div_step) begin
      dvd  <= {dvd[lcm_pkg::OPERAND_WIDTH-2:0], ge};
      part <= ge ? diff[lcm_pkg::OPERAND_WIDTH-1:0] : shifted[lcm_pkg::OPERAND_WIDTH-1:0];
      cnt  <= cnt - 1'b1;
    end

    if (cmd.set_zero) begin
      result.lcm_value          <= '0;
      result.gcd_value          <= '0;
      result.zero_operand_error <= 1'b1;
    end else if (cmd.mul) begin
      result.lcm_value          <= prod;
      result.gcd_value          <= small_op;
      result.zero_operand_error <= 1'b0;
    end
  end

  assign status.zero_op   = (a_r == '0) || (b_r == '0);
  assign status.last_step = (cnt == '0);
  assign status.rem_zero  = (part == '0);
  assign out_data         = result;

endmodule

// ===== design/lcm_ctrl.sv =====
module lcm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  lcm_pkg::dp_status_t status,
  output lcm_pkg::dp_cmd_t    cmd
);

  lcm_pkg::lcm_state_t state;
  lcm_pkg::lcm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lcm_pkg::ST_IDLE: begin
        if (in_valid) state_next = lcm_pkg::ST_CHECK;
      end
      lcm_pkg::ST_CHECK: begin
        state_next = status.zero_op ? lcm_pkg::ST_OUT : lcm_pkg::ST_MOD_RUN;
      end
      lcm_pkg::ST_MOD_RUN: begin
        if (status.last_step) state_next = lcm_pkg::ST_MOD_EVAL;
      end
      lcm_pkg::ST_MOD_EVAL: begin
        state_next = status.rem_zero ? lcm_pkg::ST_LCM_RUN : lcm_pkg::ST_CHECK;
      end
      lcm_pkg::ST_LCM_RUN: begin
        if (status.last_step) state_next = lcm_pkg::ST_MUL;
      end
      lcm_pkg::ST_MUL: begin
        state_next = lcm_pkg::ST_OUT;
      end
      lcm_pkg::ST_OUT: begin
        if (!out_stall) state_next = lcm_pkg::ST_IDLE;
      end
      default: state_next = lcm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state)
      lcm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      lcm_pkg::ST_CHECK: begin
        cmd.set_zero  = status.zero_op;
        cmd.div_start = ~status.zero_op;
      end
      lcm_pkg::ST_MOD_RUN: begin
        cmd.div_step = 1'b1;
      end
      lcm_pkg::ST_MOD_EVAL: begin
        // remainder zero: small operand is the divisor, go divide a by it
        cmd.div_start   = status.rem_zero;
        cmd.div_sel_lcm = status.rem_zero;
        cmd.swap        = ~status.rem_zero;
      end
      lcm_pkg::ST_LCM_RUN: begin
        cmd.div_step = 1'b1;
      end
      lcm_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
      end
      lcm_pkg::ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== design/lcm_by_euclid_top.sv =====
// Each accepted word runs Euclid remainder steps on the W-bit operands (W = operand
// width, 31), then divides a by the gcd and multiplies the quotient by b.
// A zero operand skips the divider and goes from the CHECK state straight to OUT.
// Rate is set by the shared one-bit-per-cycle restoring divider; one word at a time,
// the next word is taken in the cycle after the result word leaves.
// Synchronous reset returns the controller to idle; datapath registers are not cleared.
module lcm_by_euclid_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lcm_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lcm_pkg::out_word_t out_data
);

  lcm_pkg::dp_cmd_t    cmd;
  lcm_pkg::dp_status_t status;

  lcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lcm_datapath u_datapath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
